### src/cau_pkg.sv
// Shared types and constants for the complex arithmetic unit.
package cau_pkg;

  localparam int WORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int MAX_EXP_DEF   = 15;

  // Request codes
  typedef enum logic [2:0] {
    REQ_ADD = 3'd0,
    REQ_SUB = 3'd1,
    REQ_MUL = 3'd2,
    REQ_DIV = 3'd3,
    REQ_EQ  = 3'd4,
    REQ_POW = 3'd5,
    REQ_MOD = 3'd6,
    REQ_NOP = 3'd7
  } req_t;

  // Status codes
  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_DZ  = 2'd1;
  localparam logic [1:0] ST_SAT = 2'd2;

endpackage

### src/complex_arithmetic_unit.sv
// Complex arithmetic unit: pipelined complex add/sub/mul/div/eq/pow/modulus.
//
// Usage: present a request on in_valid with req_type, operands a and b
// (signed fixed point, WORD_BITS wide, FRAC_BITS fraction bits) and an
// exponent. The transaction is taken when in_valid is high and in_stall low.
// Results leave on out_valid/out_stall with r_re, r_im, is_equal, status.
//
// Every request walks the same row of NSTG register stages: capture, the
// power chain (2*ceil(log2(MAX_EXP+1)) multiply/square stages), one divide
// setup stage plus WORD_BITS+FRAC_BITS+1 quotient stages, WORD_BITS root
// stages and a final round/saturate stage (92 stages with the defaults).
// A transaction can enter every cycle while no stall holds the pipe; its
// result comes out of the same row of stages, whatever the request type.
// Throughput is one transaction per cycle when not stalled.
// A stall freezes every stage together: in_stall follows out_stall while a
// result waits at the output; nothing is lost or repeated. Reset clears all
// valid bits; payload registers are not reset.
module complex_arithmetic_unit
  import cau_pkg::*;
#(
  parameter int WORD_BITS = WORD_BITS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int MAX_EXP   = MAX_EXP_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [2:0]                  req_type,
  input  logic signed [WORD_BITS-1:0] a_re,
  input  logic signed [WORD_BITS-1:0] a_im,
  input  logic signed [WORD_BITS-1:0] b_re,
  input  logic signed [WORD_BITS-1:0] b_im,
  input  logic signed [4:0]           exponent,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [WORD_BITS-1:0] r_re,
  output logic signed [WORD_BITS-1:0] r_im,
  output logic                        is_equal,
  output logic [1:0]                  status
);

  localparam int W   = WORD_BITS;
  localparam int PW  = 2 * W + 2;          // products and their sums
  localparam int EB  = $clog2(MAX_EXP + 1);
  localparam int NM  = 2 * EB;             // power multiply stages
  localparam int QB  = W + FRAC_BITS + 1;  // quotient bits incl. round bit
  localparam int NDV = QB + 1;             // divide setup plus quotient stages
  localparam int NSQ = W;                  // root digit stages
  localparam int NSTG = 1 + NM + NDV + NSQ + 1;

  typedef logic signed [W-1:0] word_t;
  typedef logic [W-1:0] mag_t;
  typedef logic [PW-1:0] wide_t;

  typedef struct packed {
    logic [2:0]  req;
    word_t       are, aim, bre, bim;
    logic        eneg;
    logic [EB-1:0] k;
    word_t       rre, rim;      // running result / denominator source
    word_t       bsre, bsim;    // running base
    logic        sat, dz, eq;
    // divide state
    logic        nre, nim;
    logic        ovre, ovim;    // quotient too large for the word
    wide_t       mre, mim, den;
    wide_t       rmre, rmim;
    logic [QB-1:0] qre, qim;
    // root state
    wide_t       ss, sres;
  } pipe_t;

  // ---- helpers ----
  function automatic word_t pack_sm(input logic neg, input wide_t mag,
                                    output logic sat);
    wide_t topv;
    topv = wide_t'(1) << (W - 1);
    sat = 1'b0;
    if (!neg) begin
      if (mag > topv - 1) begin sat = 1'b1; return word_t'(topv - 1); end
      return word_t'(mag);
    end
    if (mag > topv) begin sat = 1'b1; return word_t'(topv); end
    return word_t'(-mag);
  endfunction

  function automatic mag_t mag_of(input word_t x);
    return x[W-1] ? mag_t'(-x) : mag_t'(x);
  endfunction

  // W x W magnitude product
  function automatic wide_t mul_mag(input word_t x, input word_t y);
    logic [2*W-1:0] pr;
    pr = mag_of(x) * mag_of(y);
    return wide_t'(pr);
  endfunction

  // exact (+/- x*y) + (+/- u*v) as sign and magnitude
  function automatic wide_t sum2(input word_t x, input word_t y, input logic f1,
                                 input word_t u, input word_t v, input logic f2,
                                 output logic neg);
    logic n1, n2;
    wide_t m1, m2, m;
    n1 = (x[W-1] ^ y[W-1]) ^ f1;
    n2 = (u[W-1] ^ v[W-1]) ^ f2;
    m1 = mul_mag(x, y);
    m2 = mul_mag(u, v);
    if (n1 == n2) begin m = m1 + m2; neg = n1; end
    else if (m1 >= m2) begin m = m1 - m2; neg = n1; end
    else begin m = m2 - m1; neg = n2; end
    if (m == 0) neg = 1'b0;
    return m;
  endfunction

  function automatic word_t round_pack(input logic neg, input wide_t mag,
                                       output logic sat);
    return pack_sm(neg, (mag + (wide_t'(1) << (FRAC_BITS - 1))) >> FRAC_BITS, sat);
  endfunction

  // ---- handshake: one global advance ----
  logic [NSTG-1:0] vld;
  pipe_t           stg [NSTG];
  logic            adv;

  assign adv       = !(vld[NSTG-1] && out_stall);
  assign in_stall  = !adv;
  assign out_valid = vld[NSTG-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NSTG-2:0], in_valid};
    end
  end

  // ---- stage 0: capture and decode ----
  always_ff @(posedge clk) begin
    logic [4:0] em;
    pipe_t      p;
    if (adv) begin
      em = exponent[4] ? 5'(-exponent) : exponent;
      if (em > 5'(MAX_EXP)) em = 5'(MAX_EXP);
      p      = '0;
      p.req  = req_type;
      p.are  = a_re;
      p.aim  = a_im;
      p.bre  = b_re;
      p.bim  = b_im;
      p.eneg = exponent[4];
      p.k    = EB'(em);
      p.rre  = word_t'(wide_t'(1) << FRAC_BITS);
      p.rim  = '0;
      p.bsre = a_re;
      p.bsim = a_im;
      stg[0] <= p;
    end
  end

  // ---- power: alternating multiply and square stages ----
  for (genvar i = 0; i < NM; i++) begin : g_pow
    always_ff @(posedge clk) begin
      pipe_t p;
      logic n, s0, s1;
      word_t t0, t1;
      wide_t m;
      if (adv) begin
        p = stg[i];
        if (p.req == REQ_POW) begin
          if (i % 2 == 0) begin
            if (p.k[i/2]) begin
              m  = sum2(p.rre, p.bsre, 1'b0, p.rim, p.bsim, 1'b1, n);
              t0 = round_pack(n, m, s0);
              m  = sum2(p.rre, p.bsim, 1'b0, p.rim, p.bsre, 1'b0, n);
              t1 = round_pack(n, m, s1);
              p.rre = t0; p.rim = t1; p.sat = p.sat | s0 | s1;
            end
          end else if ((p.k >> (i/2 + 1)) != 0) begin
            m  = sum2(p.bsre, p.bsre, 1'b0, p.bsim, p.bsim, 1'b1, n);
            t0 = round_pack(n, m, s0);
            m  = sum2(p.bsre, p.bsim, 1'b0, p.bsim, p.bsre, 1'b0, n);
            t1 = round_pack(n, m, s1);
            p.bsre = t0; p.bsim = t1; p.sat = p.sat | s0 | s1;
          end
        end
        stg[i+1] <= p;
      end
    end
  end

  // ---- division: setup stage, then one quotient bit per stage ----
  localparam int Q0 = 1 + NM;
  for (genvar j = 0; j < NDV; j++) begin : g_div
    localparam int BP = (j == 0) ? 0 : QB - j;  // quotient bit of this stage
    always_ff @(posedge clk) begin
      pipe_t p;
      word_t nre_, nim_, dre, dim;
      logic  n, isdiv;
      wide_t rm;
      if (adv) begin
        p = stg[Q0 + j - 1];
        isdiv = (p.req == REQ_DIV) || (p.req == REQ_POW && p.eneg);
        if (j == 0) begin
          if (isdiv) begin
            if (p.req == REQ_DIV) begin
              nre_ = p.are; nim_ = p.aim; dre = p.bre; dim = p.bim;
            end else begin
              nre_ = word_t'(wide_t'(1) << FRAC_BITS); nim_ = '0;
              dre = p.rre; dim = p.rim;
            end
            p.den = mul_mag(dre, dre) + mul_mag(dim, dim);
            p.mre = sum2(nre_, dre, 1'b0, nim_, dim, 1'b0, n); p.nre = n;
            p.mim = sum2(nim_, dre, 1'b0, nre_, dim, 1'b1, n); p.nim = n;
            p.dz  = (p.den == '0);
            // dividend is m*2^(FRAC+1); its bits above QB seed the remainder
            p.ovre = (p.mre >> W) >= p.den;
            p.ovim = (p.mim >> W) >= p.den;
            p.rmre = p.ovre ? '0 : (p.mre >> W);
            p.rmim = p.ovim ? '0 : (p.mim >> W);
            p.mre  = p.mre << (FRAC_BITS + 1);
            p.mim  = p.mim << (FRAC_BITS + 1);
            p.qre = '0; p.qim = '0;
          end
        end else if (isdiv && !p.dz) begin
          // restoring division, MSB first
          rm = {p.rmre[PW-2:0], p.mre[BP]};
          if (rm >= p.den) begin rm = rm - p.den; p.qre[BP] = 1'b1; end
          p.rmre = rm;
          rm = {p.rmim[PW-2:0], p.mim[BP]};
          if (rm >= p.den) begin rm = rm - p.den; p.qim[BP] = 1'b1; end
          p.rmim = rm;
        end
        stg[Q0 + j] <= p;
      end
    end
  end

  // ---- square root: one result bit per stage ----
  localparam int S0 = Q0 + NDV;
  for (genvar s = 0; s < NSQ; s++) begin : g_sqrt
    always_ff @(posedge clk) begin
      pipe_t p;
      wide_t bitv, tr;
      if (adv) begin
        p = stg[S0 + s - 1];
        if (p.req == REQ_MOD) begin
          if (s == 0) begin
            p.ss   = mul_mag(p.are, p.are) + mul_mag(p.aim, p.aim);
            p.sres = '0;
          end
          bitv = wide_t'(1) << (2 * (NSQ - 1 - s));
          tr = p.sres + bitv;
          if (p.ss >= tr) begin p.ss = p.ss - tr; p.sres = (p.sres >> 1) + bitv; end
          else p.sres = p.sres >> 1;
        end
        stg[S0 + s] <= p;
      end
    end
  end

  // ---- final stage: select, round, saturate ----
  localparam int F = S0 + NSQ;
  always_ff @(posedge clk) begin
    pipe_t p;
    logic s0, s1, n;
    wide_t sa, qx;
    logic signed [W:0] ta, tb;
    word_t o0, o1;
    if (adv) begin
      p = stg[F - 1];
      o0 = '0; o1 = '0; s0 = 1'b0; s1 = 1'b0;
      unique case (req_t'(p.req))
        REQ_ADD, REQ_SUB: begin
          if (p.req == REQ_ADD) begin
            ta = {p.are[W-1], p.are} + {p.bre[W-1], p.bre};
            tb = {p.aim[W-1], p.aim} + {p.bim[W-1], p.bim};
          end else begin
            ta = {p.are[W-1], p.are} - {p.bre[W-1], p.bre};
            tb = {p.aim[W-1], p.aim} - {p.bim[W-1], p.bim};
          end
          o0 = pack_sm(ta[W], ta[W] ? wide_t'(-ta) : wide_t'(ta), s0);
          o1 = pack_sm(tb[W], tb[W] ? wide_t'(-tb) : wide_t'(tb), s1);
        end
        REQ_MUL: begin
          sa = sum2(p.are, p.bre, 1'b0, p.aim, p.bim, 1'b1, n);
          o0 = round_pack(n, sa, s0);
          sa = sum2(p.are, p.bim, 1'b0, p.aim, p.bre, 1'b0, n);
          o1 = round_pack(n, sa, s1);
        end
        REQ_DIV, REQ_POW: begin
          if (p.req == REQ_DIV || p.eneg) begin
            if (!p.dz) begin
              qx = (wide_t'(p.qre) + wide_t'(1)) >> 1;
              if (p.ovre || (wide_t'(p.qre) >> (W + 1)) != '0) qx = wide_t'(1) << W;
              o0 = pack_sm(p.nre, qx, s0);
              qx = (wide_t'(p.qim) + wide_t'(1)) >> 1;
              if (p.ovim || (wide_t'(p.qim) >> (W + 1)) != '0) qx = wide_t'(1) << W;
              o1 = pack_sm(p.nim, qx, s1);
            end
          end else begin
            o0 = p.rre; o1 = p.rim;
          end
        end
        REQ_EQ: p.eq = (p.are == p.bre) && (p.aim == p.bim);
        REQ_MOD: begin
          sa = p.sres + wide_t'(p.ss > p.sres);
          o0 = pack_sm(1'b0, sa, s0);
        end
        default: ;
      endcase
      if (p.dz) begin o0 = '0; o1 = '0; end
      r_re     <= o0;
      r_im     <= o1;
      is_equal <= p.eq;
      status   <= p.dz ? ST_DZ : ((p.sat | s0 | s1) ? ST_SAT : ST_OK);
    end
  end

endmodule
